FILE: src/cbf_pkg.sv
// Shared types, constants and helper functions for the rectangle fill/blend engine.
package cbf_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_FILL  = 2'd1,
		ACT_BLEND = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	localparam logic CFG_WIDTH_IDX  = 1'b0;
	localparam logic CFG_HEIGHT_IDX = 1'b1;

	localparam int       ALPHA_LSB = 24;
	localparam logic [7:0] CH_MAX  = 8'hFF;

	// floor(p / 255) for p <= 255*255, via the add-and-shift identity
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
		return t[15:8];
	endfunction

endpackage

FILE: src/cbf_ram.sv
// Generic single-port RAM with registered read data.
module cbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: src/cbf_blend.sv
// Alpha blend unit: registered channel products, then divide by 255 and sum.
module cbf_blend import cbf_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dst,
	input  logic [31:0] src,
	output logic [31:0] result
);

	logic [7:0]  a;
	logic [7:0]  ia;
	logic [15:0] pd_s1 [4];
	logic [15:0] ps_s1 [3];
	logic [7:0]  a_s1;
	logic [31:0] dst_s1;
	logic [31:0] src_s1;

	assign a  = src[ALPHA_LSB +: 8];
	assign ia = CH_MAX - a;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				pd_s1[c] <= 16'(dst[8*c +: 8]) * 16'(ia);
			end
			for (int c = 0; c < 3; c++) begin
				ps_s1[c] <= 16'(src[8*c +: 8]) * 16'(a);
			end
			a_s1   <= a;
			dst_s1 <= dst;
			src_s1 <= src;
		end
	end

	always_comb begin
		if (a_s1 == CH_MAX) begin
			result = src_s1;
		end else if (a_s1 == 8'd0) begin
			result = dst_s1;
		end else begin
			result[ALPHA_LSB +: 8] = div255(pd_s1[3]) + a_s1;
			for (int c = 0; c < 3; c++) begin
				result[8*c +: 8] = div255(pd_s1[c]) + div255(ps_s1[c]);
			end
		end
	end

endmodule

FILE: src/clipped_rect_fill_blend_engine.sv
// Top level: command sequencer, clipping, pixel walker, frame store and blend unit.
//
//  channel   signals                                              direction
//  command   start, busy, action, left, top, rect_width,
//            rect_height, colour                                  in (busy out)
//  result    done, pixel_value, status                            out
//  config    cfg_wr_en, cfg_index, cfg_wr_data                    in
//
// A request is taken when start is high and busy is low; busy stays high until its result.
// Clear/fill: one store write a cycle for each clipped pixel.
// Blend: each pixel reads, multiplies, then writes the single-port store.
// Read: clip, base, read and wait states; an out-of-range read or empty rectangle ends in the clip state.
// done pulses for one cycle with the result; the receiver cannot stall it.
// Reset clears control state and sets width/height in use to 128; pixels are not cleared.
module clipped_rect_fill_blend_engine import cbf_pkg::*; #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] rect_width,
	input  logic [15:0] rect_height,
	input  logic [31:0] colour,
	output logic        done,
	output logic [31:0] pixel_value,
	output logic        status,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wr_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLIP, ST_BASE, ST_FILL, ST_BRD, ST_BMUL, ST_BWR, ST_PRD, ST_PWAIT
	} state_t;

	state_t state_q;

	logic [7:0] width_q;
	logic [7:0] height_q;

	action_t            act_q;
	logic signed [15:0] x_q, y_q, w_q, h_q;
	logic [31:0]        colour_q;

	logic [COL_W-1:0]  col_q, col_first_q, col_last_q;
	logic [ROW_W-1:0]  row_q, row_last_q;
	logic [ADDR_W-1:0] row_base_q;

	logic done_q, status_q;
	logic [31:0] pixel_q;

	logic signed [17:0] vis_w, vis_h;
	logic signed [17:0] xs, ys, ws, hs;
	logic signed [17:0] c_lo, c_end, c_hi, r_lo, r_end, r_hi;
	logic empty, rd_ok;
	logic accept, step, col_done, last_px;

	logic [ADDR_W-1:0] ram_addr;
	logic              ram_we;
	logic [31:0]       ram_wdata, ram_rdata, blend_out;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign vis_w = (width_q  > MAX_WIDTH)  ? 18'(MAX_WIDTH)  : 18'(width_q);
	assign vis_h = (height_q > MAX_HEIGHT) ? 18'(MAX_HEIGHT) : 18'(height_q);

	// clip to [max(x,0), min(x+w,vis)) on each axis
	assign xs    = 18'(x_q);
	assign ys    = 18'(y_q);
	assign ws    = 18'(w_q);
	assign hs    = 18'(h_q);
	assign c_lo  = (xs < 18'sd0) ? 18'sd0 : xs;
	assign r_lo  = (ys < 18'sd0) ? 18'sd0 : ys;
	assign c_end = xs + ws;
	assign r_end = ys + hs;
	assign c_hi  = (c_end > vis_w) ? vis_w : c_end;
	assign r_hi  = (r_end > vis_h) ? vis_h : r_end;
	assign empty = (c_hi <= c_lo) || (r_hi <= r_lo);
	assign rd_ok = (xs >= 18'sd0) && (ys >= 18'sd0) && (xs < vis_w) && (ys < vis_h);

	assign step     = (state_q == ST_FILL) || (state_q == ST_BWR);
	assign col_done = (col_q == col_last_q);
	assign last_px  = col_done && (row_q == row_last_q);

	assign ram_addr  = row_base_q + ADDR_W'(col_q);
	assign ram_we    = step;
	assign ram_wdata = (state_q == ST_BWR) ? blend_out : colour_q;

	cbf_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cbf_blend u_blend (
		.clk    (clk),
		.en     (state_q == ST_BMUL),
		.dst    (ram_rdata),
		.src    (colour_q),
		.result (blend_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			height_q <= 8'd128;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIDTH_IDX:  width_q  <= cfg_wr_data;
				CFG_HEIGHT_IDX: height_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(action);
			colour_q <= colour;
			if (action_t'(action) == ACT_CLEAR) begin
				x_q <= 16'sd0;
				y_q <= 16'sd0;
				w_q <= 16'(vis_w);
				h_q <= 16'(vis_h);
			end else begin
				x_q <= left;
				y_q <= top;
				w_q <= rect_width;
				h_q <= rect_height;
			end
		end
		if (state_q == ST_CLIP) begin
			col_first_q <= COL_W'(c_lo);
			col_last_q  <= COL_W'(c_hi - 18'sd1);
			row_q       <= ROW_W'(r_lo);
			row_last_q  <= ROW_W'(r_hi - 18'sd1);
		end
		if (state_q == ST_BASE) begin
			row_base_q <= ADDR_W'(row_q * MAX_WIDTH);
			col_q      <= col_first_q;
		end
		if (step) begin
			if (col_done) begin
				col_q      <= col_first_q;
				row_q      <= row_q + ROW_W'(1);
				row_base_q <= row_base_q + ADDR_W'(MAX_WIDTH);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			pixel_q  <= 32'd0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					if (act_q == ACT_READ) begin
						if (rd_ok) begin
							state_q <= ST_BASE;
						end else begin
							state_q  <= ST_IDLE;
							done_q   <= 1'b1;
							pixel_q  <= 32'd0;
							status_q <= 1'b1;
						end
					end else if (empty) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						pixel_q  <= 32'd0;
						status_q <= 1'b0;
					end else begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					case (act_q)
						ACT_READ:  state_q <= ST_PRD;
						ACT_BLEND: state_q <= ST_BRD;
						default:   state_q <= ST_FILL;
					endcase
				end
				ST_FILL: begin
					if (last_px) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						pixel_q  <= 32'd0;
						status_q <= 1'b0;
					end
				end
				ST_BRD:  state_q <= ST_BMUL;
				ST_BMUL: state_q <= ST_BWR;
				ST_BWR: begin
					if (last_px) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						pixel_q  <= 32'd0;
						status_q <= 1'b0;
					end else begin
						state_q <= ST_BRD;
					end
				end
				ST_PRD:  state_q <= ST_PWAIT;
				ST_PWAIT: begin
					state_q  <= ST_IDLE;
					done_q   <= 1'b1;
					pixel_q  <= ram_rdata;
					status_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign pixel_value = pixel_q;
	assign status      = status_q;

endmodule
